@@ rtl/rar_pkg.sv @@
// Shared types and constants for the rational add-and-reduce block.
// No dependencies; imported by rational_add_reduce_top.
package rar_pkg;

   // Width of each signed input field
   localparam int OPERAND_WIDTH = 16;

   // Magnitude of one cross product sum (sum of two products of W-bit magnitudes of at most 2**(W-1))
   localparam int MAG_W = 2 * OPERAND_WIDTH;

   // Output field widths
   localparam int NUM_OUT_W = 32;
   localparam int DEN_OUT_W = 31;

   // Iteration counter for the bit-serial divider
   localparam int CNT_W = $clog2(MAG_W + 1);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SUM,
      ST_TWOS,
      ST_STRIP,
      ST_LOOP,
      ST_DIVN,
      ST_DIVD,
      ST_WRITE
   } state_type;

   // Magnitude of a two's complement operand; the most negative value
   // maps to its full magnitude, which still fits unsigned in W bits.
   function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
      logic [OPERAND_WIDTH-1:0] neg_v;
      neg_v = ~v + 1'b1;
      return v[OPERAND_WIDTH-1] ? neg_v : v;
   endfunction

endpackage

@@ rtl/rational_add_reduce_top.sv @@
// Rational fraction adder with reduction to lowest terms.
// Depends on rar_pkg for widths, the state type and the magnitude helper.

// Adds two signed fractions and returns the sum as a sign plus reduced
// numerator and denominator magnitudes. One request word is taken at a
// time; req_ready is low while it is being worked on. Steps, from the
// accept cycle to the response word: accept, three multiplies on a
// single shared multiplier, the sum, removal of the common power of two,
// shifts that make the first GCD term odd, then a binary GCD (one halve,
// swap or subtract per cycle, ending on the cycle that finds both terms
// equal), then two exact bit-serial divisions by the GCD, all on one
// shared subtractor, and the load of the response register, which waits
// while the response slot is full. A zero denominator skips straight to
// the response write; a zero sum skips the GCD and divisions.
// The response register holds a finished word until it is taken, so the
// next request can be accepted meanwhile.
module rational_add_reduce_top import rar_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_negative,
   output logic [NUM_OUT_W-1:0]            rsp_sum_num,
   output logic [DEN_OUT_W-1:0]            rsp_sum_den,
   output logic                            rsp_den_error
);

   state_type state_ff, state_in;

   // Operand registers
   logic                     sa_ff, sb_ff;
   logic [OPERAND_WIDTH-1:0] ma_ff, da_ff, mb_ff, db_ff;
   logic [MAG_W-1:0]         t1_ff, t2_ff;

   // Working registers: n/d hold numerator and denominator, then quotients
   logic                     neg_ff, err_ff;
   logic [MAG_W-1:0]         n_ff, d_ff, x_ff, y_ff, rem_ff;
   logic [CNT_W-1:0]         cnt_ff;

   // Response register
   logic                     rsp_valid_ff, rsp_neg_ff, rsp_err_ff;
   logic [MAG_W-1:0]         rsp_num_ff, rsp_den_ff;

   // Shared multiplier and subtractor
   logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic [MAG_W-1:0]         mul_res;
   logic [MAG_W:0]           sub_a;
   logic [MAG_W-1:0]         sub_b;
   logic [MAG_W+1:0]         sub_res;
   logic                     sub_borrow;
   logic                     sub_zero;

   // Sum of the cross products
   logic                     same_sign, t1_ge;
   logic [MAG_W-1:0]         sum_mag;
   logic                     sum_neg;

   logic                     in_fire, den_zero, slot_free, div_last;

   assign in_fire   = req_valid && req_ready;
   assign den_zero  = (req_a_den == '0) || (req_b_den == '0);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign div_last  = (cnt_ff == CNT_W'(MAG_W - 1));

   assign mul_res    = MAG_W'(mul_a) * MAG_W'(mul_b);
   assign sub_res    = {1'b0, sub_a} - {2'b00, sub_b};
   assign sub_borrow = sub_res[MAG_W+1];
   assign sub_zero   = (sub_res == '0);

   assign same_sign = (sa_ff == sb_ff);
   assign t1_ge     = (t1_ff >= t2_ff);

   // Signed add of the two cross products
   always_comb begin
      if (same_sign) begin
         sum_mag = t1_ff + t2_ff;
         sum_neg = sa_ff;
      end else if (t1_ge) begin
         sum_mag = t1_ff - t2_ff;
         sum_neg = sa_ff;
      end else begin
         sum_mag = t2_ff - t1_ff;
         sum_neg = sb_ff;
      end
   end

   // Control outputs and shared unit operand selection
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_a     = ma_ff;
      mul_b     = db_ff;
      sub_a     = {1'b0, y_ff};
      sub_b     = x_ff;
      unique case (state_ff)
         ST_MUL2: begin
            mul_a = mb_ff;
            mul_b = da_ff;
         end
         ST_MUL3: begin
            mul_a = da_ff;
            mul_b = db_ff;
         end
         ST_DIVN: sub_a = {rem_ff, n_ff[MAG_W-1]};
         ST_DIVD: sub_a = {rem_ff, d_ff[MAG_W-1]};
         default: ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (in_fire) state_in = den_zero ? ST_WRITE : ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_SUM;
         ST_SUM:   state_in = (sum_mag == '0) ? ST_WRITE : ST_TWOS;
         ST_TWOS:  if (n_ff[0] || d_ff[0]) state_in = ST_STRIP;
         ST_STRIP: if (x_ff[0]) state_in = ST_LOOP;
         ST_LOOP:  if (y_ff[0] && !sub_borrow && sub_zero) state_in = ST_DIVN;
         ST_DIVN:  if (div_last) state_in = ST_DIVD;
         ST_DIVD:  if (div_last) state_in = ST_WRITE;
         ST_WRITE: if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (in_fire) begin
               ma_ff  <= mag_of(req_a_num);
               da_ff  <= mag_of(req_a_den);
               mb_ff  <= mag_of(req_b_num);
               db_ff  <= mag_of(req_b_den);
               sa_ff  <= req_a_num[OPERAND_WIDTH-1] ^ req_a_den[OPERAND_WIDTH-1];
               sb_ff  <= req_b_num[OPERAND_WIDTH-1] ^ req_b_den[OPERAND_WIDTH-1];
               err_ff <= den_zero;
               neg_ff <= 1'b0;
               n_ff   <= '0;
               d_ff   <= '0;
            end
         end
         ST_MUL1: t1_ff <= mul_res;
         ST_MUL2: t2_ff <= mul_res;
         ST_MUL3: d_ff  <= mul_res;
         ST_SUM: begin
            // zero sum reads as 0/1, positive
            if (sum_mag == '0) begin
               n_ff   <= '0;
               d_ff   <= MAG_W'(1);
               neg_ff <= 1'b0;
            end else begin
               n_ff   <= sum_mag;
               neg_ff <= sum_neg;
            end
         end
         ST_TWOS: begin
            // strip the common power of two from both terms
            if (!n_ff[0] && !d_ff[0]) begin
               n_ff <= n_ff >> 1;
               d_ff <= d_ff >> 1;
            end else begin
               x_ff <= n_ff;
               y_ff <= d_ff;
            end
         end
         ST_STRIP: if (!x_ff[0]) x_ff <= x_ff >> 1;
         ST_LOOP: begin
            // binary GCD on odd x: halve y, swap, or subtract
            if (!y_ff[0]) begin
               y_ff <= y_ff >> 1;
            end else if (sub_borrow) begin
               x_ff <= y_ff;
               y_ff <= x_ff;
            end else if (sub_zero) begin
               rem_ff <= '0;
               cnt_ff <= '0;
            end else begin
               y_ff <= sub_res[MAG_W-1:0];
            end
         end
         ST_DIVN: begin
            // restoring division, quotient shifts into n
            n_ff <= {n_ff[MAG_W-2:0], !sub_borrow};
            if (div_last) begin
               rem_ff <= '0;
               cnt_ff <= '0;
            end else begin
               rem_ff <= sub_borrow ? sub_a[MAG_W-1:0] : sub_res[MAG_W-1:0];
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         ST_DIVD: begin
            rem_ff <= sub_borrow ? sub_a[MAG_W-1:0] : sub_res[MAG_W-1:0];
            d_ff   <= {d_ff[MAG_W-2:0], !sub_borrow};
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_WRITE && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE && slot_free) begin
         rsp_neg_ff <= neg_ff;
         rsp_num_ff <= n_ff;
         rsp_den_ff <= d_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_negative  = rsp_neg_ff;
   assign rsp_sum_num   = NUM_OUT_W'(rsp_num_ff);
   assign rsp_sum_den   = DEN_OUT_W'(rsp_den_ff);
   assign rsp_den_error = rsp_err_ff;

endmodule

@@ sim/rational_add_reduce_top_tb.sv @@
// Self-checking testbench for rational_add_reduce_top: fraction sums in lowest terms.
// Depends on rar_pkg and rational_add_reduce_top; the predictor is written in-house.
module rational_add_reduce_top_tb import rar_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [OPERAND_WIDTH-1:0] operand_type;

   typedef struct packed {
      logic                 negative;
      logic [NUM_OUT_W-1:0] sum_num;
      logic [DEN_OUT_W-1:0] sum_den;
      logic                 den_error;
   } reduced_sum_type;

   localparam operand_type OP_MAX = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
   localparam operand_type OP_MIN = ~OP_MAX;

   // Predicts the reduced sum for each accepted word and checks responses in order
   class reduced_sum_board;
      reduced_sum_type pending_sums[$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
      endfunction

      // full magnitude, most negative value included
      static function longint unsigned magnitude(operand_type v);
         longint wide;
         wide = v;
         return (wide < 0) ? longint'(-wide) : longint'(wide);
      endfunction

      static function longint unsigned euclid(longint unsigned x, longint unsigned y);
         longint unsigned r;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         return x;
      endfunction

      static function reduced_sum_type reduced_sum(operand_type an, operand_type ad,
                                                   operand_type bn, operand_type bd);
         reduced_sum_type res;
         longint unsigned ma, da, mb, db, t1, t2, den, mag, g;
         logic            sa, sb, neg;
         res = '0;
         ma = magnitude(an);
         da = magnitude(ad);
         mb = magnitude(bn);
         db = magnitude(bd);
         if (da == 0 || db == 0) begin
            res.den_error = 1'b1;
            return res;
         end
         sa  = an[OPERAND_WIDTH-1] ^ ad[OPERAND_WIDTH-1];
         sb  = bn[OPERAND_WIDTH-1] ^ bd[OPERAND_WIDTH-1];
         t1  = ma * db;
         t2  = mb * da;
         den = da * db;
         if (sa == sb) begin
            mag = t1 + t2;
            neg = sa;
         end else if (t1 >= t2) begin
            mag = t1 - t2;
            neg = sa;
         end else begin
            mag = t2 - t1;
            neg = sb;
         end
         // zero sum is always 0/1, positive
         if (mag == 0) begin
            res.sum_den = DEN_OUT_W'(1);
            return res;
         end
         g = euclid(mag, den);
         res.negative = neg;
         res.sum_num  = NUM_OUT_W'(mag / g);
         res.sum_den  = DEN_OUT_W'(den / g);
         return res;
      endfunction

      function void note_request(operand_type an, operand_type ad,
                                 operand_type bn, operand_type bd);
         pending_sums.push_back(reduced_sum(an, ad, bn, bd));
      endfunction

      function void check_response(reduced_sum_type got);
         reduced_sum_type want;
         if (pending_sums.size() == 0) begin
            $display("%0t: response with none pending: neg=%0d num=%0d den=%0d err=%0d",
                     $time, got.negative, got.sum_num, got.sum_den, got.den_error);
            mismatches++;
            return;
         end
         want = pending_sums.pop_front();
         if (got.negative !== want.negative) begin
            $display("%0t: negative: expected %0d, actual %0d",
                     $time, want.negative, got.negative);
            mismatches++;
         end
         if (got.sum_num !== want.sum_num) begin
            $display("%0t: sum_num: expected %0d, actual %0d",
                     $time, want.sum_num, got.sum_num);
            mismatches++;
         end
         if (got.sum_den !== want.sum_den) begin
            $display("%0t: sum_den: expected %0d, actual %0d",
                     $time, want.sum_den, got.sum_den);
            mismatches++;
         end
         if (got.den_error !== want.den_error) begin
            $display("%0t: den_error: expected %0d, actual %0d",
                     $time, want.den_error, got.den_error);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   operand_type          req_a_num;
   operand_type          req_a_den;
   operand_type          req_b_num;
   operand_type          req_b_den;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_negative;
   logic [NUM_OUT_W-1:0] rsp_sum_num;
   logic [DEN_OUT_W-1:0] rsp_sum_den;
   logic                 rsp_den_error;

   reduced_sum_board board = new();
   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;

   rational_add_reduce_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_a_num     (req_a_num),
      .req_a_den     (req_a_den),
      .req_b_num     (req_b_num),
      .req_b_den     (req_b_den),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_negative  (rsp_negative),
      .rsp_sum_num   (rsp_sum_num),
      .rsp_sum_den   (rsp_sum_den),
      .rsp_den_error (rsp_den_error)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response side: ready changes on the falling edge, words taken on the rising edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_response({rsp_negative, rsp_sum_num, rsp_sum_den, rsp_den_error});
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_fractions(operand_type an, operand_type ad,
                                 operand_type bn, operand_type bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(an, ad, bn, bd);
      @(negedge clock);
   endtask

   // Mix of raw bit patterns, small values, extremes and scaled multiples
   function automatic operand_type pick_operand();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 35)
         return operand_type'($urandom);
      else if (sel < 70)
         return operand_type'(int'($urandom_range(24)) - 12);
      else if (sel < 85) begin
         case ($urandom_range(5))
            0: return OP_MIN;
            1: return OP_MIN + 1;
            2: return OP_MAX;
            3: return operand_type'(-1);
            4: return operand_type'(1);
            default: return '0;
         endcase
      end else
         return operand_type'((int'($urandom_range(30)) - 15) * (1 << $urandom_range(10)));
   endfunction

   task automatic send_random_fractions();
      operand_type an, ad, bn, bd;
      int unsigned shape;
      an = pick_operand();
      ad = pick_operand();
      bn = pick_operand();
      bd = pick_operand();
      shape = $urandom_range(99);
      // opposite fractions cancel to zero; shared denominators reduce often
      if (shape < 15) begin
         bn = -an;
         bd = ad;
      end else if (shape < 25)
         bd = ad;
      else if (shape < 30)
         bd = -ad;
      send_fractions(an, ad, bn, bd);
   endtask

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_a_num      = '0;
      req_a_den      = '0;
      req_b_num      = '0;
      req_b_den      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed cases
      send_fractions(1, 2, 1, 3);
      send_fractions(1, 2, -1, 2);
      send_fractions(-1, 2, -1, 3);
      send_fractions(3, -6, -4, 8);
      send_fractions(5, 5, -5, 5);
      send_fractions(1, 0, 1, 3);
      send_fractions(1, 3, 1, 0);
      send_fractions(0, 0, 0, 0);
      send_fractions(0, 5, 0, -7);
      send_fractions(OP_MIN, 1, 0, 1);
      send_fractions(OP_MIN, OP_MIN, OP_MIN, 1);
      send_fractions(OP_MAX, 1, OP_MAX, 1);
      send_fractions(OP_MIN, 1, OP_MIN, 1);
      send_fractions(OP_MIN, -1, OP_MIN, -1);
      send_fractions(OP_MAX, OP_MIN, OP_MIN, OP_MAX);
      send_fractions(1, OP_MAX, 1, OP_MIN);
      send_fractions(OP_MAX, OP_MAX, OP_MIN, OP_MIN);
      send_fractions(-1, OP_MIN, -1, OP_MIN);
      send_fractions(OP_MIN, OP_MAX, OP_MAX, OP_MIN);
      send_fractions(6, 4, 10, -4);
      send_fractions(-7, -1, 7, 1);
      send_fractions(12, 18, 20, 30);

      // random traffic in rotating idle/stall phases
      for (int i = 0; i < 950; i++) begin
         case ((i / 80) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         send_random_fractions();
      end
      req_valid <= 1'b0;

      // drain, then allow for a late stray response
      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
